// ----- rtl/utf8d_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types and constants of the UTF-8 to code point decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [30:0] code_point;
    logic [1:0]  status;
    logic        end_of_string;
  } out_item_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;

  localparam int          CFG_ADDR_W     = 3;
  localparam int          MAX_CHARS_W    = 16;
  localparam logic        REG_MAX_CHARS  = 1'b0;
  localparam logic [15:0] MAX_CHARS_RST  = 16'hFFFF;

endpackage

// ----- rtl/utf8d_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_cfg
// APB-style register file holding the character capacity.
// ----------------------------------------------------------------------------
module utf8d_cfg (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [utf8d_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready,
  output logic [utf8d_pkg::MAX_CHARS_W-1:0]      max_chars
);

  logic [utf8d_pkg::MAX_CHARS_W-1:0] max_chars_r;
  logic                              reg_hit;

  // register index sits at bit 2 of the byte address
  assign reg_hit = (paddr[2] == utf8d_pkg::REG_MAX_CHARS);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= utf8d_pkg::MAX_CHARS_RST;
    end else if (psel && penable && pwrite && reg_hit) begin
      max_chars_r <= pwdata[utf8d_pkg::MAX_CHARS_W-1:0];
    end
  end

  always_comb begin
    prdata = 32'd0;
    if (reg_hit) begin
      prdata[utf8d_pkg::MAX_CHARS_W-1:0] = max_chars_r;
    end
  end

  assign max_chars = max_chars_r;

endmodule

// ----- rtl/utf8d_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8d_core
// Input register, per-string decode state and result register.
// ----------------------------------------------------------------------------
module utf8d_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [utf8d_pkg::MAX_CHARS_W-1:0]    max_chars,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  utf8d_pkg::in_item_t                  in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output utf8d_pkg::out_item_t                 out_data
);

  localparam int CMP_W = (COUNT_BITS > utf8d_pkg::MAX_CHARS_W) ?
                         COUNT_BITS : utf8d_pkg::MAX_CHARS_W;

  // input stage
  logic                 s1_valid_r;
  utf8d_pkg::in_item_t  s1_data_r;

  // decode state
  logic [2:0]            rem_r, rem_nxt;
  logic [30:0]           acc_r, acc_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic                  halted_r, halted_nxt;

  // result stage
  logic                  out_valid_r;
  utf8d_pkg::out_item_t  out_data_r;

  logic                  s2_free;
  logic                  fire;
  logic                  at_cap;
  logic                  emit;
  utf8d_pkg::out_item_t  res;
  logic [2:0]            need;
  logic [6:0]            payload;
  logic                  bad_lead;
  logic [7:0]            b;
  logic                  last;
  logic [30:0]           acc_shift;
  logic [2:0]            rem_dec;

  assign s2_free  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s2_free;
  assign fire     = s1_valid_r && s2_free;

  assign b    = s1_data_r.byte_in;
  assign last = s1_data_r.last_byte;

  assign at_cap = (CMP_W'(count_r) >= CMP_W'(max_chars)) || (&count_r);

  // lead byte classes
  always_comb begin
    need     = 3'd0;
    payload  = 7'd0;
    bad_lead = 1'b0;
    if (b[7] == 1'b0) begin
      payload = b[6:0];
    end else if (b[7:5] == 3'b110) begin
      need    = 3'd1;
      payload = {2'b00, b[4:0]};
    end else if (b[7:4] == 4'b1110) begin
      need    = 3'd2;
      payload = {3'b000, b[3:0]};
    end else if (b[7:3] == 5'b11110) begin
      need    = 3'd3;
      payload = {4'b0000, b[2:0]};
    end else if (b[7:2] == 6'b111110) begin
      need    = 3'd4;
      payload = {5'b00000, b[1:0]};
    end else if (b[7:1] == 7'b1111110) begin
      need    = 3'd5;
      payload = {6'b000000, b[0]};
    end else begin
      bad_lead = 1'b1;
    end
  end

  assign acc_shift = {acc_r[24:0], b[5:0]};
  assign rem_dec   = rem_r - 3'd1;

  always_comb begin
    rem_nxt    = rem_r;
    acc_nxt    = acc_r;
    count_nxt  = count_r;
    halted_nxt = halted_r;
    emit       = 1'b0;
    res        = '{code_point: 31'd0, status: utf8d_pkg::ST_OK, end_of_string: last};

    if (halted_r || at_cap) begin
      // byte dropped
    end else if (rem_r == 3'd0) begin
      if (bad_lead) begin
        emit       = 1'b1;
        res.status = utf8d_pkg::ST_BAD_LEAD;
        halted_nxt = 1'b1;
      end else if (need == 3'd0) begin
        emit           = 1'b1;
        res.code_point = {24'd0, payload};
        count_nxt      = count_r + COUNT_BITS'(1);
      end else if (last) begin
        emit       = 1'b1;
        res.status = utf8d_pkg::ST_TRUNC;
      end else begin
        rem_nxt = need;
        acc_nxt = {24'd0, payload};
      end
    end else begin
      rem_nxt = rem_dec;
      acc_nxt = acc_shift;
      if (rem_dec == 3'd0) begin
        emit           = 1'b1;
        res.code_point = acc_shift;
        count_nxt      = count_r + COUNT_BITS'(1);
        acc_nxt        = 31'd0;
      end else if (last) begin
        emit       = 1'b1;
        res.status = utf8d_pkg::ST_TRUNC;
      end
    end

    // end of string starts a fresh one
    if (last) begin
      rem_nxt    = 3'd0;
      acc_nxt    = 31'd0;
      count_nxt  = '0;
      halted_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      rem_r       <= 3'd0;
      acc_r       <= 31'd0;
      count_r     <= '0;
      halted_r    <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (s2_free) begin
        out_valid_r <= fire && emit;
      end
      if (fire) begin
        rem_r    <= rem_nxt;
        acc_r    <= acc_nxt;
        count_r  <= count_nxt;
        halted_r <= halted_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data_r <= in_data;
    end
    if (fire && emit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/utf8_to_code_point_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_code_point_decoder
// Decodes a UTF-8 byte stream (1 to 6 byte sequences) into code points.
// Pipeline: an accepted byte sits in the input register, and its result, if
// any, is then held in the result register until it is taken.
// Throughput: one byte per cycle while the result register is not stalled,
// set by the single decode pass between the input and result registers.
// Reset: synchronous active-low rst_n empties both stages, clears the
// decode state and sets the capacity register to 65535.
// ----------------------------------------------------------------------------
module utf8_to_code_point_decoder #(
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // byte input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  utf8d_pkg::in_item_t               in_data,
  // decoded result
  output logic                              out_valid,
  input  logic                              out_stall,
  output utf8d_pkg::out_item_t              out_data,
  // register port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [utf8d_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [utf8d_pkg::MAX_CHARS_W-1:0] max_chars;

  utf8d_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .max_chars (max_chars)
  );

  utf8d_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_chars (max_chars),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 to code point decoder. Bytes go in over
// the input channel with random gaps, results are taken with random stalls,
// and every result is checked against an in-bench decode of the same bytes.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int COUNT_BITS = 16;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;
  localparam logic [utf8d_pkg::CFG_ADDR_W-1:0] ADDR_MAX_CHARS =
    {utf8d_pkg::REG_MAX_CHARS, 2'b00};
  localparam logic [utf8d_pkg::CFG_ADDR_W-1:0] ADDR_SPARE = {1'b1, 2'b00};
  localparam int HOLD_CYCLES = 150;
  localparam int RUN_LIMIT = 300000;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  utf8d_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  utf8d_pkg::out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [utf8d_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // decode state mirrored by the bench
  logic [2:0] bytes_left_q = '0;
  logic [30:0] acc_q = '0;
  logic [15:0] char_cnt_q = '0;
  logic halted_q = 1'b0;
  logic [15:0] max_chars_q;

  utf8d_pkg::out_item_t expected_points[$];
  int errors = 0;
  int cfg_errors;
  int sent_bytes;
  bit in_gaps;
  bit out_gaps;
  bit hold_req;

  always #1 clk = ~clk;

  utf8_to_code_point_decoder #(
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  function automatic void clear_string_state();
    bytes_left_q = '0;
    acc_q = '0;
    char_cnt_q = '0;
    halted_q = 1'b0;
  endfunction

  // one byte through the decoder; returns whether a result comes out
  function automatic void decode_byte(input utf8d_pkg::in_item_t it, output bit produced,
                                      output utf8d_pkg::out_item_t res);
    logic [2:0] need;
    logic [30:0] payload;
    produced = 1'b0;
    res = '0;
    res.end_of_string = it.last_byte;
    if (halted_q || char_cnt_q >= max_chars_q || char_cnt_q == COUNT_TOP) begin
      // skipped until the end mark
    end else if (bytes_left_q == 3'd0) begin
      need = 3'd0;
      payload = '0;
      casez (it.byte_in)
        8'b0???????: payload = {24'd0, it.byte_in[6:0]};
        8'b110?????: begin
          need = 3'd1;
          payload = {26'd0, it.byte_in[4:0]};
        end
        8'b1110????: begin
          need = 3'd2;
          payload = {27'd0, it.byte_in[3:0]};
        end
        8'b11110???: begin
          need = 3'd3;
          payload = {28'd0, it.byte_in[2:0]};
        end
        8'b111110??: begin
          need = 3'd4;
          payload = {29'd0, it.byte_in[1:0]};
        end
        8'b1111110?: begin
          need = 3'd5;
          payload = {30'd0, it.byte_in[0]};
        end
        default: begin
          produced = 1'b1;
          res.status = utf8d_pkg::ST_BAD_LEAD;
          halted_q = 1'b1;
        end
      endcase
      if (!produced) begin
        if (need == 3'd0) begin
          produced = 1'b1;
          res.code_point = payload;
          res.status = utf8d_pkg::ST_OK;
          char_cnt_q++;
        end else if (it.last_byte) begin
          produced = 1'b1;
          res.status = utf8d_pkg::ST_TRUNC;
        end else begin
          bytes_left_q = need;
          acc_q = payload;
        end
      end
    end else begin
      acc_q = {acc_q[24:0], it.byte_in[5:0]};
      bytes_left_q--;
      if (bytes_left_q == 3'd0) begin
        produced = 1'b1;
        res.code_point = acc_q;
        res.status = utf8d_pkg::ST_OK;
        char_cnt_q++;
        acc_q = '0;
      end else if (it.last_byte) begin
        produced = 1'b1;
        res.status = utf8d_pkg::ST_TRUNC;
      end
    end
    if (it.last_byte) clear_string_state();
  endfunction

  // results are checked before new bytes are decoded, so a result can never
  // be matched against a byte accepted at the same edge
  always @(posedge clk) begin
    bit produced;
    utf8d_pkg::out_item_t res;
    utf8d_pkg::out_item_t exp_item;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, actual cp=%h st=%0d eos=%0b", $time,
                 out_data.code_point, out_data.status, out_data.end_of_string);
      end else begin
        exp_item = expected_points.pop_front();
        if (out_data.code_point !== exp_item.code_point ||
            out_data.status !== exp_item.status ||
            out_data.end_of_string !== exp_item.end_of_string) begin
          errors++;
          $display("%0t: mismatch, expected cp=%h st=%0d eos=%0b, actual cp=%h st=%0d eos=%0b",
                   $time, exp_item.code_point, exp_item.status, exp_item.end_of_string,
                   out_data.code_point, out_data.status, out_data.end_of_string);
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      decode_byte(in_data, produced, res);
      if (produced) expected_points.push_back(res);
    end
  end

  // receiver side: random stall bursts, or one long hold when asked
  initial begin
    bit hold_taken;
    hold_taken = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (out_gaps && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (RUN_LIMIT) @(posedge clk);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input bit last);
    utf8d_pkg::in_item_t it;
    it.byte_in = b;
    it.last_byte = last;
    if (in_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_bytes++;
  endtask

  // lets the pipeline drain; bytes with no result may still be in flight
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [utf8d_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_MAX_CHARS) max_chars_q = data[15:0];
  endtask

  task automatic cfg_read_check(input logic [utf8d_pkg::CFG_ADDR_W-1:0] addr,
                                input logic [31:0] exp_data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (pready !== 1'b1 || prdata !== exp_data) begin
      cfg_errors++;
      $display("%0t: register read mismatch, expected %h, actual %h", $time,
               exp_data, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // sends the first 'sent' bytes of a len-byte sequence with random payload
  task automatic send_char(input int len, input int sent, input bit fin);
    logic [31:0] r;
    logic [7:0] lead;
    r = $urandom;
    case (len)
      1: lead = {1'b0, r[6:0]};
      2: lead = {3'b110, r[4:0]};
      3: lead = {4'b1110, r[3:0]};
      4: lead = {5'b11110, r[2:0]};
      5: lead = {6'b111110, r[1:0]};
      default: lead = {7'b1111110, r[0]};
    endcase
    for (int k = 0; k < sent; k++) begin
      r = $urandom;
      send_byte((k == 0) ? lead : {2'b10, r[5:0]}, fin && (k == sent - 1));
    end
  endtask

  task automatic send_random_string();
    int n_chars;
    int kind;
    int len;
    bit fin;
    logic [31:0] r;
    n_chars = $urandom_range(1, 6);
    for (int c = 0; c < n_chars; c++) begin
      fin = (c == n_chars - 1);
      kind = $urandom_range(0, 19);
      r = $urandom;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: len = 1;
        4, 5: len = 2;
        6: len = 3;
        7: len = 4;
        8: len = 5;
        default: len = 6;
      endcase
      if (kind == 0) begin
        send_byte(r[7:0], fin);
      end else if (kind == 1) begin
        send_byte(r[8] ? {2'b10, r[5:0]} : {7'b1111111, r[0]}, fin);
      end else if (kind == 2 && fin && len > 1) begin
        send_char(len, $urandom_range(1, len - 1), 1'b1);
      end else begin
        send_char(len, len, fin);
      end
    end
  endtask

  task automatic run_random_phase(input logic [15:0] cap, input bit gaps, input int target);
    int start;
    wait_drained();
    cfg_write(ADDR_MAX_CHARS, {16'd0, cap});
    in_gaps = gaps;
    out_gaps = gaps;
    start = sent_bytes;
    while (sent_bytes - start < target) send_random_string();
  endtask

  task automatic test_single_byte();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b1);
  endtask

  task automatic test_multi_byte();
    send_byte(8'hDF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b0);
    send_byte(8'hAC, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h98, 1'b0);
    send_byte(8'h80, 1'b0);
    // six-byte sequence with every payload bit set
    send_byte(8'hFD, 1'b0);
    repeat (4) send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  task automatic test_bad_lead();
    // everything after a bad lead is skipped up to the end mark
    send_byte(8'h80, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_truncated();
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
    send_byte(8'hC2, 1'b1);
  endtask

  task automatic test_capacity();
    wait_drained();
    cfg_write(ADDR_MAX_CHARS, 32'd1);
    // a write to an unmapped register changes nothing
    cfg_write(ADDR_SPARE, 32'd3);
    cfg_read_check(ADDR_MAX_CHARS, 32'd1);
    send_byte(8'h41, 1'b0);
    send_byte(8'h42, 1'b0);
    send_byte(8'hC2, 1'b1);
  endtask

  task automatic test_backpressure();
    wait_drained();
    cfg_write(ADDR_MAX_CHARS, {16'd0, utf8d_pkg::MAX_CHARS_RST});
    in_gaps = 1'b0;
    out_gaps = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < 40; i++) send_byte(8'h20 + i[7:0], (i % 10) == 9);
  endtask

  task automatic test_random();
    run_random_phase(utf8d_pkg::MAX_CHARS_RST, 1'b1, 110);
    run_random_phase(16'd1, 1'b1, 70);
    run_random_phase(16'($urandom_range(2, 3)), 1'b0, 60);
    run_random_phase(16'($urandom_range(4, 65535)), 1'b1, 70);
    // closing stretch with no idling on either side
    run_random_phase(utf8d_pkg::MAX_CHARS_RST, 1'b0, 70);
  endtask

  initial begin
    cfg_errors = 0;
    sent_bytes = 0;
    in_gaps = 1'b1;
    out_gaps = 1'b1;
    hold_req = 1'b0;
    max_chars_q = utf8d_pkg::MAX_CHARS_RST;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_single_byte();
    test_multi_byte();
    test_bad_lead();
    test_truncated();
    test_capacity();
    test_backpressure();
    test_random();

    wait_drained();
    repeat (10) @(posedge clk);
    if (errors == 0 && cfg_errors == 0 && expected_points.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/utf8d_pkg.sv
rtl/utf8d_cfg.sv
rtl/utf8d_core.sv
rtl/utf8_to_code_point_decoder.sv
sim/tb_top.sv
